@@ design/merp_pkg.sv @@
// Shared types, codes and sizes of the MIPS relocation patcher.
`default_nettype none

package merp_pkg;

    localparam int MERP_PENDING_DEPTH = 16;

    // Operation codes
    localparam logic OP_RELOCATE = 1'b0;
    localparam logic OP_FINISH   = 1'b1;

    // ELF relocation types handled
    localparam logic [7:0] TYPE_WORD32 = 8'd2;
    localparam logic [7:0] TYPE_JUMP26 = 8'd4;
    localparam logic [7:0] TYPE_HIGH16 = 8'd5;
    localparam logic [7:0] TYPE_LOW16  = 8'd6;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_TYPE  = 2'd1;
    localparam logic [1:0] ST_UNMATCHED = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    // One parked high16 record
    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] base;
        logic [31:0] word;
        logic [15:0] symbol;
    } entry_t;

endpackage

`default_nettype wire

@@ design/merp_if.sv @@
// Record and patch channel interfaces of the MIPS relocation patcher.
`default_nettype none

interface merp_rec_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [7:0]  reloc_type;
    logic [31:0] instr_word;
    logic [31:0] site_offset;
    logic [31:0] reloc_base;
    logic [15:0] symbol_id;

    modport source (output valid, operation, reloc_type, instr_word, site_offset,
                    reloc_base, symbol_id, input ready);
    modport sink   (input valid, operation, reloc_type, instr_word, site_offset,
                    reloc_base, symbol_id, output ready);
endinterface

interface merp_patch_if;
    logic        valid;
    logic        ready;
    logic [31:0] patch_offset;
    logic [31:0] patch_word;
    logic        last;
    logic [1:0]  status;

    modport source (output valid, patch_offset, patch_word, last, status, input ready);
    modport sink   (input valid, patch_offset, patch_word, last, status, output ready);
endinterface

`default_nettype wire

@@ design/mips_elf_relocation_patcher_top.sv @@
// Top level of the MIPS relocation patcher: sequencer, pending table, result register.
//
// Usage
//   rec   : relocation records and finish requests, valid/ready, taken on valid & ready.
//   patch : patched words with their offsets, valid/ready, one registered result stage.
//   word32, jump26, high16, unknown type and finish each give one result, from the
//   result state into the output register once that register is free or being taken.
//   A low16 record walks the pending table through its one read port, one entry a
//   cycle while no matching result waits on patch. Each entry with the same symbol
//   gives a result (last = 0) in table order; other entries are written back packed
//   toward the front. The low16 patch itself follows with last = 1.
//   rec.ready is high only while the sequencer is idle, one item at a time; a final
//   result may still sit in the output register when the next item is taken.
//   When patch stalls, the result holds and the table walk pauses on the entry
//   whose result cannot be placed, so no result is lost.
//   Reset clears the pending count, the sequencer and the output valid; table
//   contents are left as they are, only entries below the count are read.
//   A high16 record against a full table is echoed with status full and not parked.
`default_nettype none

module mips_elf_relocation_patcher_top
    import merp_pkg::*;
#(
    parameter int PENDING_DEPTH = MERP_PENDING_DEPTH
) (
    input  wire         clk,
    input  wire         rst_n,
    merp_rec_if.sink    rec,
    merp_patch_if.source patch
);

    localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
    localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_RESULT = 2'd2;

    // Sequencer state
    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] keep_reg, keep_next;
    logic             rdv_reg, rdv_next;

    // Held item
    logic        op_reg;
    logic [7:0]  type_reg;
    logic [31:0] word_reg;
    logic [31:0] site_reg;
    logic [31:0] base_reg;
    logic [15:0] sym_reg;

    // Pending table, one read and one write port, registered read
    entry_t             pend_mem [PENDING_DEPTH];
    entry_t             rdata_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    entry_t             mem_wdata;
    logic               mem_re;
    logic [IDX_W-1:0]   mem_raddr;

    // Output register
    logic        out_valid_reg;
    logic [31:0] out_offset_reg;
    logic [31:0] out_word_reg;
    logic        out_last_reg;
    logic [1:0]  out_status_reg;

    logic        out_load;
    logic [31:0] load_offset;
    logic [31:0] load_word;
    logic        load_last;
    logic [1:0]  load_status;

    logic        rec_acc;
    logic        slot_free;
    logic        match;
    logic        consume;
    logic        table_full;
    logic [31:0] fin_offset;
    logic [31:0] fin_word;
    logic [1:0]  fin_status;
    logic [31:0] res_full;
    logic [15:0] res_upper;

    assign rec.ready  = (state_reg == S_IDLE);
    assign rec_acc    = rec.valid && rec.ready;
    assign slot_free  = !out_valid_reg || patch.ready;
    assign table_full = (count_reg == CNT_W'(PENDING_DEPTH));

    // high16 resolution against the low16 record's word
    assign res_full  = {rdata_reg.word[15:0], 16'h0000}
                     + {{16{word_reg[15]}}, word_reg[15:0]}
                     + rdata_reg.base;
    assign res_upper = res_full[31:16] + {15'd0, res_full[15]};

    assign match   = (rdata_reg.symbol == sym_reg);
    assign consume = rdv_reg && (!match || slot_free);

    // Final result of the held item
    always_comb
    begin
        fin_offset = site_reg;
        fin_word   = word_reg;
        fin_status = ST_OK;
        if (op_reg == OP_FINISH)
        begin
            fin_offset = '0;
            fin_word   = '0;
            fin_status = (count_reg != '0) ? ST_UNMATCHED : ST_OK;
        end
        else
        begin
            case (type_reg)
                TYPE_WORD32: fin_word = word_reg + base_reg;
                TYPE_JUMP26: fin_word = {word_reg[31:26], word_reg[25:0] + base_reg[27:2]};
                TYPE_HIGH16: fin_status = table_full ? ST_FULL : ST_OK;
                TYPE_LOW16:  fin_word = {word_reg[31:16], word_reg[15:0] + base_reg[15:0]};
                default:     fin_status = ST_BAD_TYPE;
            endcase
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        rd_idx_next = rd_idx_reg;
        rdv_next    = rdv_reg;
        keep_next   = keep_reg;
        mem_we      = 1'b0;
        mem_waddr   = keep_reg[IDX_W-1:0];
        mem_wdata   = rdata_reg;
        mem_re      = 1'b0;
        mem_raddr   = rd_idx_reg[IDX_W-1:0];
        out_load    = 1'b0;
        load_offset = fin_offset;
        load_word   = fin_word;
        load_last   = 1'b1;
        load_status = fin_status;

        case (state_reg)
            S_IDLE:
            begin
                if (rec_acc)
                begin
                    if (rec.operation == OP_RELOCATE && rec.reloc_type == TYPE_LOW16
                        && count_reg != '0)
                    begin
                        mem_re      = 1'b1;
                        mem_raddr   = '0;
                        rd_idx_next = CNT_W'(1);
                        rdv_next    = 1'b1;
                        keep_next   = '0;
                        state_next  = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end

            S_SCAN:
            begin
                if (consume)
                begin
                    if (match)
                    begin
                        out_load    = 1'b1;
                        load_offset = rdata_reg.offset;
                        load_word   = {rdata_reg.word[31:16], res_upper};
                        load_last   = 1'b0;
                        load_status = ST_OK;
                    end
                    else
                    begin
                        // keep index never passes the read index: no overlap
                        mem_we    = 1'b1;
                        keep_next = keep_reg + CNT_W'(1);
                    end
                end
                if (!rdv_reg || consume)
                begin
                    if (rd_idx_reg < count_reg)
                    begin
                        mem_re      = 1'b1;
                        rd_idx_next = rd_idx_reg + CNT_W'(1);
                        rdv_next    = 1'b1;
                    end
                    else
                    begin
                        rdv_next   = 1'b0;
                        count_next = keep_next;
                        state_next = S_RESULT;
                    end
                end
            end

            S_RESULT:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    if (op_reg == OP_RELOCATE && type_reg == TYPE_HIGH16 && !table_full)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = count_reg[IDX_W-1:0];
                        mem_wdata  = '{offset: site_reg, base: base_reg,
                                       word: word_reg, symbol: sym_reg};
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            keep_reg      <= '0;
            rdv_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            keep_reg      <= keep_next;
            rdv_reg       <= rdv_next;
            out_valid_reg <= out_load ? 1'b1 : (out_valid_reg && !patch.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_acc)
        begin
            op_reg   <= rec.operation;
            type_reg <= rec.reloc_type;
            word_reg <= rec.instr_word;
            site_reg <= rec.site_offset;
            base_reg <= rec.reloc_base;
            sym_reg  <= rec.symbol_id;
        end
        if (out_load)
        begin
            out_offset_reg <= load_offset;
            out_word_reg   <= load_word;
            out_last_reg   <= load_last;
            out_status_reg <= load_status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pend_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= pend_mem[mem_raddr];
        end
    end

    assign patch.valid        = out_valid_reg;
    assign patch.patch_offset = out_offset_reg;
    assign patch.patch_word   = out_word_reg;
    assign patch.last         = out_last_reg;
    assign patch.status       = out_status_reg;

endmodule

`default_nettype wire

@@ design/merp_checker.sv @@
// Port-level assertions for the MIPS relocation patcher, bound to the top level.
`default_nettype none

module merp_checker
    import merp_pkg::*;
(
    input wire        clk,
    input wire        rst_n,
    input wire        rec_ready,
    input wire        patch_valid,
    input wire        patch_ready,
    input wire [31:0] patch_offset,
    input wire [31:0] patch_word,
    input wire        patch_last,
    input wire [1:0]  patch_status
);

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        patch_valid && !patch_ready |=> patch_valid)
        else $error("patch result dropped while stalled");

    // Resolved high16 results are never flagged
    a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        patch_valid && !patch_last |-> patch_status == ST_OK)
        else $error("non-final result with error status");

    // Error results end their item
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        patch_valid && patch_status != ST_OK |-> patch_last)
        else $error("error status on a non-final result");

    // No new record while a table walk still owes results
    a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
        patch_valid && !patch_last |-> !rec_ready)
        else $error("record taken during a table walk");

    // Unmatched report carries a zero offset and word
    a_finish_zero: assert property (@(posedge clk) disable iff (!rst_n)
        patch_valid && patch_status == ST_UNMATCHED |-> patch_offset == '0 && patch_word == '0)
        else $error("finish result with nonzero payload");

endmodule

bind mips_elf_relocation_patcher_top merp_checker u_merp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rec_ready    (rec.ready),
    .patch_valid  (patch.valid),
    .patch_ready  (patch.ready),
    .patch_offset (patch.patch_offset),
    .patch_word   (patch.patch_word),
    .patch_last   (patch.last),
    .patch_status (patch.status)
);

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the MIPS relocation patcher: directed and random items, scoreboard.

module tb;
    import merp_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 5;
    localparam int RANDOM_ITEMS = 240;
    // Longest legal quiet stretch is the long receiver hold; allow ten times that.
    localparam int LONG_HOLD    = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int TAIL_CYCLES  = 24;

    // One record item as offered on the rec channel
    typedef struct packed {
        logic        operation;
        logic [7:0]  reloc_type;
        logic [31:0] instr_word;
        logic [31:0] site_offset;
        logic [31:0] reloc_base;
        logic [15:0] symbol_id;
    } rec_item_t;

    // One patch item as seen on the patch channel
    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] word;
        logic        last;
        logic [1:0]  status;
    } patch_item_t;

    typedef enum {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    // Scoreboard: mirrors the pending high16 table and queues the patches it implies.
    class patch_scoreboard;
        entry_t      parked[MERP_PENDING_DEPTH];
        int          parked_count;
        patch_item_t due_patches[$];
        int          fail_count;

        function new();
            parked_count = 0;
            fail_count   = 0;
        endfunction

        function int due_count();
            return due_patches.size();
        endfunction

        function void add_due(logic [31:0] offset, logic [31:0] word, logic last,
                              logic [1:0] status);
            patch_item_t p;
            p.offset = offset;
            p.word   = word;
            p.last   = last;
            p.status = status;
            due_patches = {due_patches, p};
        endfunction

        // Paired high16: rebuild full addend, sign-extended low half, round bit 15 up.
        function logic [31:0] resolve_high16(logic [31:0] hi_word, logic [31:0] base,
                                             logic [31:0] lo_word);
            logic [31:0] full;
            logic [15:0] upper;
            full  = {hi_word[15:0], 16'h0000} + {{16{lo_word[15]}}, lo_word[15:0]} + base;
            upper = full[31:16] + {15'd0, full[15]};
            return {hi_word[31:16], upper};
        endfunction

        function void note_record(rec_item_t r);
            int          keep;
            int          i;
            logic [25:0] jump;
            logic [15:0] low;
            if (r.operation == OP_FINISH)
            begin
                add_due(32'd0, 32'd0, 1'b1, (parked_count != 0) ? ST_UNMATCHED : ST_OK);
                return;
            end
            case (r.reloc_type)
                TYPE_WORD32: add_due(r.site_offset, r.instr_word + r.reloc_base, 1'b1, ST_OK);
                TYPE_JUMP26:
                begin
                    jump = r.instr_word[25:0] + r.reloc_base[27:2];
                    add_due(r.site_offset, {r.instr_word[31:26], jump}, 1'b1, ST_OK);
                end
                TYPE_HIGH16:
                begin
                    if (parked_count >= MERP_PENDING_DEPTH)
                    begin
                        add_due(r.site_offset, r.instr_word, 1'b1, ST_FULL);
                    end
                    else
                    begin
                        parked[parked_count].offset = r.site_offset;
                        parked[parked_count].base   = r.reloc_base;
                        parked[parked_count].word   = r.instr_word;
                        parked[parked_count].symbol = r.symbol_id;
                        parked_count++;
                        add_due(r.site_offset, r.instr_word, 1'b1, ST_OK);
                    end
                end
                TYPE_LOW16:
                begin
                    keep = 0;
                    for (i = 0; i < parked_count; i++)
                    begin
                        if (parked[i].symbol == r.symbol_id)
                        begin
                            add_due(parked[i].offset,
                                    resolve_high16(parked[i].word, parked[i].base,
                                                   r.instr_word),
                                    1'b0, ST_OK);
                        end
                        else
                        begin
                            parked[keep] = parked[i];
                            keep++;
                        end
                    end
                    parked_count = keep;
                    low = r.instr_word[15:0] + r.reloc_base[15:0];
                    add_due(r.site_offset, {r.instr_word[31:16], low}, 1'b1, ST_OK);
                end
                default: add_due(r.site_offset, r.instr_word, 1'b1, ST_BAD_TYPE);
            endcase
        endfunction

        function void check_patch(patch_item_t got);
            patch_item_t want;
            if (due_patches.size() == 0)
            begin
                $error("patch item with nothing due: offset %h word %h", got.offset, got.word);
                fail_count++;
                return;
            end
            want = due_patches.pop_front();
            if (got.offset !== want.offset)
            begin
                $error("patch_offset expected %h actual %h", want.offset, got.offset);
                fail_count++;
            end
            if (got.word !== want.word)
            begin
                $error("patch_word expected %h actual %h", want.word, got.word);
                fail_count++;
            end
            if (got.last !== want.last)
            begin
                $error("last expected %b actual %b", want.last, got.last);
                fail_count++;
            end
            if (got.status !== want.status)
            begin
                $error("status expected %0d actual %0d", want.status, got.status);
                fail_count++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    merp_rec_if   rec_ch();
    merp_patch_if patch_ch();

    mips_elf_relocation_patcher_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rec   (rec_ch),
        .patch (patch_ch)
    );

    patch_scoreboard sb = new();

    // Sender pacing
    int items_sent;
    int burst_left;
    bit gaps_on;

    // Long receiver hold: main toggles hold_req, receiver counts the hold itself
    logic hold_req;

    // Symbols that high16 and low16 records pair on; random-type items may park others
    logic [15:0] sym_pool[4];

    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic rec_item_t make_record(logic op, logic [7:0] kind, logic [31:0] word,
                                              logic [31:0] site, logic [31:0] base,
                                              logic [15:0] sym);
        rec_item_t r;
        r.operation   = op;
        r.reloc_type  = kind;
        r.instr_word  = word;
        r.site_offset = site;
        r.reloc_base  = base;
        r.symbol_id   = sym;
        return r;
    endfunction

    function automatic rec_item_t random_record(logic [7:0] kind, logic [15:0] sym);
        return make_record(OP_RELOCATE, kind, $urandom, $urandom, $urandom, sym);
    endfunction

    function automatic logic [15:0] pool_sym();
        return sym_pool[$urandom_range(0, 3)];
    endfunction

    // Offer one item, hold it until taken, then note it. Gaps fall between bursts.
    task automatic offer_record(input rec_item_t it);
        int gap;
        rec_ch.valid       <= 1'b1;
        rec_ch.operation   <= it.operation;
        rec_ch.reloc_type  <= it.reloc_type;
        rec_ch.instr_word  <= it.instr_word;
        rec_ch.site_offset <= it.site_offset;
        rec_ch.reloc_base  <= it.reloc_base;
        rec_ch.symbol_id   <= it.symbol_id;
        @(posedge clk);
        while (!rec_ch.ready) @(posedge clk);
        sb.note_record(it);
        items_sent++;
        if (gaps_on && burst_left == 0)
        begin
            gap        = $urandom_range(1, 12);
            burst_left = $urandom_range(0, 15);
            rec_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        else if (burst_left > 0)
        begin
            burst_left--;
        end
    endtask

    // Stop offering until every due patch has come back.
    task automatic drain_patches();
        rec_ch.valid <= 1'b0;
        while (sb.due_count() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Clear the pool symbols, then park past capacity on one symbol and resolve: full-table
    // echo plus, unless other symbols stay parked, the largest result burst a low16 can give.
    task automatic fill_and_resolve();
        int k;
        for (k = 0; k < 4; k++) offer_record(random_record(TYPE_LOW16, sym_pool[k]));
        repeat (MERP_PENDING_DEPTH + 1) offer_record(random_record(TYPE_HIGH16, sym_pool[0]));
        offer_record(random_record(TYPE_LOW16, sym_pool[0]));
    endtask

    task automatic run_directed();
        int i;
        // finish ignores the type field; empty table gives ok
        offer_record(make_record(OP_FINISH, TYPE_LOW16, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF, 16'hFFFF));
        // word32 wrap at 2^32
        offer_record(make_record(OP_RELOCATE, TYPE_WORD32, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 32'h0000_0001, 16'hFFFF));
        // jump26: low 26 bits wrap, top 6 kept
        offer_record(make_record(OP_RELOCATE, TYPE_JUMP26, 32'hFFFF_FFFF, 32'h0000_0000,
                                 32'hFFFF_FFFF, 16'h0000));
        offer_record(make_record(OP_RELOCATE, TYPE_JUMP26, 32'hFC00_0000, 32'h0040_0000,
                                 32'h0000_0004, 16'h0000));
        // unknown types echo the word
        offer_record(make_record(OP_RELOCATE, 8'h00, 32'h1234_5678, 32'h0000_0010,
                                 32'h0000_0000, 16'h0000));
        offer_record(make_record(OP_RELOCATE, 8'hFF, 32'h8765_4321, 32'h0000_0014,
                                 32'hFFFF_FFFF, 16'hFFFF));
        // fill the table; two entries on a second symbol so the resolve compacts
        for (i = 0; i < MERP_PENDING_DEPTH; i++)
        begin
            offer_record(make_record(OP_RELOCATE, TYPE_HIGH16, $urandom, 32'h0000_1000 + 4 * i,
                                     (i == 0) ? 32'hFFFF_FFFF : $urandom,
                                     (i == 3 || i == 10) ? 16'h0000 : 16'hFFFF));
        end
        // table full: echoed with full status, not parked
        offer_record(make_record(OP_RELOCATE, TYPE_HIGH16, 32'h3C01_ABCD, 32'h0000_2000,
                                 32'h1111_1111, 16'hFFFF));
        // entries left over at finish
        offer_record(make_record(OP_FINISH, 8'h00, 32'd0, 32'd0, 32'd0, 16'd0));
        // negative low half, then positive low half with an all-ones base
        offer_record(make_record(OP_RELOCATE, TYPE_LOW16, 32'h2421_8000, 32'h0000_3000,
                                 $urandom, 16'hFFFF));
        offer_record(make_record(OP_RELOCATE, TYPE_LOW16, 32'h2421_7FFF, 32'h0000_3004,
                                 32'hFFFF_FFFF, 16'h0000));
        offer_record(make_record(OP_FINISH, 8'h00, 32'd0, 32'd0, 32'd0, 16'd0));
    endtask

    // One random scenario; most often high16/low16 pairings on the pool symbols.
    task automatic run_scenario();
        int pick;
        int n;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            n = $urandom_range(1, 5);
            repeat (n)
            begin
                offer_record(random_record(TYPE_HIGH16, pool_sym()));
                if ($urandom_range(0, 9) < 3)
                begin
                    offer_record(random_record($urandom_range(0, 1) ? TYPE_WORD32 : TYPE_JUMP26,
                                               16'($urandom)));
                end
            end
            offer_record(random_record(TYPE_LOW16, pool_sym()));
        end
        else if (pick < 68)
        begin
            offer_record(random_record($urandom_range(0, 1) ? TYPE_WORD32 : TYPE_JUMP26,
                                       16'($urandom)));
        end
        else if (pick < 78)
        begin
            // any type byte; known codes land here too
            offer_record(random_record(8'($urandom), 16'($urandom)));
        end
        else if (pick < 86)
        begin
            offer_record(make_record(OP_FINISH, 8'($urandom), $urandom, $urandom, $urandom,
                                     16'($urandom)));
        end
        else if (pick < 92)
        begin
            // low16 on a symbol that is likely not parked
            offer_record(random_record(TYPE_LOW16, 16'($urandom)));
        end
        else if (pick < 94)
        begin
            fill_and_resolve();
        end
        else
        begin
            // stray high16 with no low16 behind it
            offer_record(random_record(TYPE_HIGH16, pool_sym()));
        end
    endtask

    // Receiver: checks each taken patch, stalls on its own mode pattern,
    // and holds off for the long receiver hold whenever hold_req toggles.
    initial
    begin
        rx_mode_t   rx_mode;
        int         rx_left;
        int         hold_left;
        logic       hold_ack;
        logic [7:0] rx_phase;
        patch_item_t got;
        patch_ch.ready <= 1'b0;
        rx_mode   = RX_ALWAYS;
        rx_left   = 0;
        hold_left = 0;
        hold_ack  = 1'b0;
        rx_phase  = 8'd0;
        @(posedge clk);
        forever
        begin
            if (rst_n && patch_ch.valid && patch_ch.ready)
            begin
                got.offset = patch_ch.patch_offset;
                got.word   = patch_ch.patch_word;
                got.last   = patch_ch.last;
                got.status = patch_ch.status;
                sb.check_patch(got);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                patch_ch.ready <= 1'b0;
            end
            else if (hold_req !== hold_ack)
            begin
                hold_ack  = hold_req;
                hold_left = LONG_HOLD - 1;
                patch_ch.ready <= 1'b0;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = rx_mode_t'($urandom_range(0, 3));
                    rx_left = $urandom_range(20, 150);
                end
                rx_left--;
                rx_phase++;
                case (rx_mode)
                    RX_ALWAYS:   patch_ch.ready <= 1'b1;
                    RX_HALF:     patch_ch.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   patch_ch.ready <= ($urandom_range(0, 4) == 0);
                    RX_PERIODIC: patch_ch.ready <= (rx_phase[1:0] == 2'b00);
                    default:     patch_ch.ready <= 1'b1;
                endcase
            end
            @(posedge clk);
        end
    end

    // Watchdog: too many cycles with no item moving on either channel.
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((rec_ch.valid && rec_ch.ready) || (patch_ch.valid && patch_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Main sequence
    initial
    begin
        int  random_start;
        bit  hold_done;
        bit  fill_done;
        bit  drain_done;
        rst_n              <= 1'b0;
        hold_req           <= 1'b0;
        rec_ch.valid       <= 1'b0;
        rec_ch.operation   <= OP_RELOCATE;
        rec_ch.reloc_type  <= 8'd0;
        rec_ch.instr_word  <= 32'd0;
        rec_ch.site_offset <= 32'd0;
        rec_ch.reloc_base  <= 32'd0;
        rec_ch.symbol_id   <= 16'd0;
        items_sent = 0;
        burst_left = 0;
        gaps_on    = 1'b1;
        hold_done  = 1'b0;
        fill_done  = 1'b0;
        drain_done = 1'b0;
        sym_pool[0] = 16'h0000;
        sym_pool[1] = 16'hFFFF;
        sym_pool[2] = 16'($urandom);
        sym_pool[3] = 16'($urandom);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain_patches();

        random_start = items_sent;
        while (items_sent < random_start + RANDOM_ITEMS)
        begin
            // some scenarios run with the sender never idling
            gaps_on = ($urandom_range(0, 4) != 0);
            if (!hold_done && items_sent >= random_start + 90)
            begin
                // receiver holds off while items keep coming: block fills, rec stalls
                hold_done = 1'b1;
                hold_req <= ~hold_req;
                gaps_on = 1'b0;
                repeat (12) offer_record(random_record(TYPE_WORD32, 16'($urandom)));
                gaps_on = 1'b1;
            end
            else if (!fill_done && items_sent >= random_start + 140)
            begin
                fill_done = 1'b1;
                fill_and_resolve();
            end
            else if (!drain_done && items_sent >= random_start + 180)
            begin
                drain_done = 1'b1;
                drain_patches();
            end
            else
            begin
                run_scenario();
            end
        end

        rec_ch.valid <= 1'b0;
        while (sb.due_count() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.fail_count == 0 && sb.due_count() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
